// File: src/uhf_pkg.sv
// Shared types and constants for the half-bit UART receiver with byte ring.
// No dependencies; imported by every module of the block.
package uhf_pkg;

    localparam int RING_DEPTH_DEF = 64;
    localparam int OQ_DEPTH       = 4;
    localparam int OQ_PTR_W       = $clog2(OQ_DEPTH);

    localparam logic [1:0] CMD_LINE  = 2'd0;
    localparam logic [1:0] CMD_TICK  = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;
    localparam logic [1:0] CMD_FLUSH = 2'd3;

    typedef struct packed {
        logic [1:0] cmd;
        logic       rx_level;
    } t_in_word;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       byte_valid;
        logic       frame_active;
        logic [5:0] fill_count;
        logic       byte_dropped;
    } t_out_word;

    // completed frame leaving the deframer
    typedef struct packed {
        logic       push;
        logic [7:0] data;
    } t_frame_evt;

    // per-word status collected at accept time
    typedef struct packed {
        logic       byte_valid;
        logic       frame_active;
        logic [5:0] fill_count;
        logic       byte_dropped;
    } t_step_stat;

endpackage

// File: src/uhf_deframer.sv
// 8N1 deframer state machine driven by line events and half-bit ticks.
// Depends on uhf_pkg.
module uhf_deframer import uhf_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_acc,
    input  t_in_word   i_in_word,
    input  logic       i_line_invert,
    output t_frame_evt o_evt,
    output logic       o_frame_active
);

    localparam logic [2:0] PH_IDLE  = 3'd0;
    localparam logic [2:0] PH_START = 3'd1;
    localparam logic [2:0] PH_HALF  = 3'd2;
    localparam logic [2:0] PH_DATA  = 3'd3;
    localparam logic [2:0] PH_STOP  = 3'd4;

    logic [2:0] r_phase, n_phase;
    logic [7:0] r_shift_byte, n_shift_byte;
    logic [7:0] r_bit_select, n_bit_select;
    logic       start_level;

    assign start_level = i_in_word.rx_level ~^ i_line_invert;

    always_comb begin
        n_phase      = r_phase;
        n_shift_byte = r_shift_byte;
        n_bit_select = r_bit_select;
        o_evt.push   = 1'b0;
        o_evt.data   = r_shift_byte ^ {8{i_line_invert}};
        if (i_acc) begin
            case (i_in_word.cmd)
                CMD_LINE: begin
                    if (r_phase == PH_IDLE && start_level) begin
                        n_phase = PH_START;
                    end
                end
                CMD_TICK: begin
                    case (r_phase)
                        PH_START: begin
                            if (start_level) begin
                                n_bit_select = 8'd1;
                                n_shift_byte = 8'd0;
                                n_phase      = PH_HALF;
                            end else begin
                                n_phase = PH_IDLE;
                            end
                        end
                        PH_HALF: begin
                            n_phase = (r_bit_select == 8'd0) ? PH_STOP : PH_DATA;
                        end
                        PH_DATA: begin
                            if (i_in_word.rx_level) begin
                                n_shift_byte = r_shift_byte | r_bit_select;
                            end else begin
                                n_shift_byte = r_shift_byte & ~r_bit_select;
                            end
                            n_bit_select = {r_bit_select[6:0], 1'b0};
                            n_phase      = PH_HALF;
                        end
                        PH_STOP: begin
                            o_evt.push = i_in_word.rx_level ^ i_line_invert;
                            n_phase    = PH_IDLE;
                        end
                        default: begin
                            n_phase = r_phase;
                        end
                    endcase
                end
                default: begin
                    n_phase = r_phase;
                end
            endcase
        end
    end

    assign o_frame_active = (n_phase != PH_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_bit_select <= 8'd0;
        end else begin
            r_phase      <= n_phase;
            r_bit_select <= n_bit_select;
        end
    end

    always_ff @(posedge i_clk) begin
        r_shift_byte <= n_shift_byte;
    end

    a_data_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DATA) |-> $onehot(r_bit_select))
        else $error("bit select not one-hot in data phase");

endmodule

// File: src/uhf_ring.sv
// Byte ring buffer: one write port for received frames, one registered read port.
// Depends on uhf_pkg.
module uhf_ring import uhf_pkg::*; #(
    parameter int RING_DEPTH = RING_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_acc,
    input  logic [1:0] i_cmd,
    input  t_frame_evt i_evt,
    output logic       o_byte_valid,
    output logic       o_byte_dropped,
    output logic [5:0] o_fill_count,
    output logic [7:0] o_rd_data
);

    localparam int PTR_W = $clog2(RING_DEPTH);
    localparam int FW    = (PTR_W + 1 > 6) ? PTR_W + 1 : 6;
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(RING_DEPTH - 1);

    logic [7:0]       r_mem [RING_DEPTH];
    logic [7:0]       r_rd_data;
    logic [PTR_W-1:0] r_wp, n_wp, r_rp, n_rp;
    logic [PTR_W-1:0] wp_inc, rp_inc;
    logic             full, empty, do_push, do_read, do_flush;
    logic [FW-1:0]    fill;

    assign wp_inc   = (r_wp == PTR_LAST) ? '0 : r_wp + 1'b1;
    assign rp_inc   = (r_rp == PTR_LAST) ? '0 : r_rp + 1'b1;
    assign full     = (wp_inc == r_rp);
    assign empty    = (r_wp == r_rp);
    assign do_push  = i_evt.push && !full;
    assign do_read  = i_acc && (i_cmd == CMD_READ) && !empty;
    assign do_flush = i_acc && (i_cmd == CMD_FLUSH);

    always_comb begin
        n_wp = r_wp;
        n_rp = r_rp;
        if (do_flush) begin
            n_wp = '0;
            n_rp = '0;
        end else begin
            if (do_push) begin
                n_wp = wp_inc;
            end
            if (do_read) begin
                n_rp = rp_inc;
            end
        end
    end

    assign fill = FW'(n_wp) - FW'(n_rp) + ((n_wp < n_rp) ? FW'(RING_DEPTH) : FW'(0));

    assign o_byte_valid   = do_read;
    assign o_byte_dropped = i_evt.push && full;
    assign o_fill_count   = fill[5:0];
    assign o_rd_data      = r_rd_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
        end else begin
            r_wp <= n_wp;
            r_rp <= n_rp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_evt.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_read) begin
            r_rd_data <= r_mem[r_rp];
        end
    end

    a_flush_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_flush |=> (r_wp == '0 && r_rp == '0))
        else $error("flush did not clear ring pointers");

    a_ptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_wp <= PTR_LAST) && (r_rp <= PTR_LAST))
        else $error("ring pointer out of range");

endmodule

// File: src/uhf_out_queue.sv
// Result stage and four-word output queue; aligns registered ring read data.
// Depends on uhf_pkg.
module uhf_out_queue import uhf_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_acc,
    input  t_step_stat i_stat,
    input  logic [7:0] i_rd_data,
    output logic       o_in_ready,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_out_word  o_out_word
);

    logic                r_s1_valid;
    t_step_stat          r_s1_stat;
    t_out_word           r_q [OQ_DEPTH];
    logic [OQ_PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [OQ_PTR_W:0]   r_count, n_count;
    logic                push, pop;
    t_out_word           s1_word;

    assign s1_word.rx_byte      = r_s1_stat.byte_valid ? i_rd_data : 8'd0;
    assign s1_word.byte_valid   = r_s1_stat.byte_valid;
    assign s1_word.frame_active = r_s1_stat.frame_active;
    assign s1_word.fill_count   = r_s1_stat.fill_count;
    assign s1_word.byte_dropped = r_s1_stat.byte_dropped;

    assign push        = r_s1_valid;
    assign pop         = o_out_valid && i_out_ready;
    assign o_out_valid = (r_count != '0);
    assign o_out_word  = r_q[r_rd_ptr];
    // credit covers the word in the result stage as well
    assign o_in_ready  = (r_count + (OQ_PTR_W + 1)'(r_s1_valid))
                         < (OQ_PTR_W + 1)'(OQ_DEPTH);

    always_comb begin
        n_count = r_count;
        if (push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (pop && !push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_wr_ptr   <= '0;
            r_rd_ptr   <= '0;
            r_count    <= '0;
        end else begin
            r_s1_valid <= i_acc;
            r_count    <= n_count;
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_acc) begin
            r_s1_stat <= i_stat;
        end
        if (push) begin
            r_q[r_wr_ptr] <= s1_word;
        end
    end

    a_room_for_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid |-> (r_count < (OQ_PTR_W + 1)'(OQ_DEPTH)))
        else $error("result stage has no room in output queue");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (OQ_PTR_W + 1)'(OQ_DEPTH))
        else $error("output queue count overflow");

endmodule

// File: src/uart_rx_halfbit_fifo.sv
// Top level of the half-bit UART receiver with byte ring buffer.
// Depends on uhf_pkg, uhf_deframer, uhf_ring, uhf_out_queue.
//
// Takes input words (line event, half-bit tick, read, flush) and returns exactly
// one result word per input. State, ring pointers and the ring write are updated
// at the accepting edge; the ring read data is registered, so a result enters the
// output queue in the cycle after its input is accepted. Sustained rate is one
// word per cycle while i_out_ready is high; a four-word output queue lets input
// continue while results wait, and o_in_ready drops when the queue and the result
// stage together hold four words. The ring holds RING_DEPTH-1 bytes; its contents
// are undefined until written and need no clearing. The line polarity flag
// (1 = idle low, data inverted) is written through i_cfg_we/i_cfg_wdata; the user
// must do so only while the block is idle, which the block does not enforce.
module uart_rx_halfbit_fifo import uhf_pkg::*; #(
    parameter int RING_DEPTH = RING_DEPTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cfg_we,
    input  logic      i_cfg_wdata,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_word o_out_word
);

    logic       r_line_invert;
    logic       acc;
    t_frame_evt evt;
    t_step_stat stat;
    logic       frame_active;
    logic       byte_valid, byte_dropped;
    logic [5:0] fill_count;
    logic [7:0] rd_data;

    assign acc = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_invert <= 1'b0;
        end else if (i_cfg_we) begin
            r_line_invert <= i_cfg_wdata;
        end
    end

    uhf_deframer u_deframer (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_acc          (acc),
        .i_in_word      (i_in_word),
        .i_line_invert  (r_line_invert),
        .o_evt          (evt),
        .o_frame_active (frame_active)
    );

    uhf_ring #(
        .RING_DEPTH(RING_DEPTH)
    ) u_ring (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_acc         (acc),
        .i_cmd         (i_in_word.cmd),
        .i_evt         (evt),
        .o_byte_valid  (byte_valid),
        .o_byte_dropped(byte_dropped),
        .o_fill_count  (fill_count),
        .o_rd_data     (rd_data)
    );

    assign stat.byte_valid   = byte_valid;
    assign stat.frame_active = frame_active;
    assign stat.fill_count   = fill_count;
    assign stat.byte_dropped = byte_dropped;

    uhf_out_queue u_out_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_acc      (acc),
        .i_stat     (stat),
        .i_rd_data  (rd_data),
        .o_in_ready (o_in_ready),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_word (o_out_word)
    );

endmodule

// File: dv/tb_uart_rx_halfbit_fifo.sv
// Testbench for uart_rx_halfbit_fifo: drives line events, half-bit ticks, reads and
// flushes, predicts every result word in a tracker class and checks each field.
// Depends on uhf_pkg and uart_rx_halfbit_fifo.
module tb_uart_rx_halfbit_fifo;
    import uhf_pkg::*;

    localparam int STALL_LIMIT   = 2000;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 10;

    typedef enum logic [2:0] {LP_IDLE, LP_START, LP_HALF, LP_DATA, LP_STOP} t_line_phase;
    typedef enum logic [1:0] {FR_GOOD, FR_BAD_START, FR_BAD_STOP} t_frame_fault;

    class rx_ring_tracker;
        bit          inverse = 1'b0;
        t_line_phase phase = LP_IDLE;
        logic [7:0]  shifter = '0;
        logic [7:0]  bit_mask = '0;
        logic [7:0]  ring [RING_DEPTH_DEF];
        int unsigned rd_ptr = 0;
        int unsigned wr_ptr = 0;
        t_out_word   due_words [$];
        int          errors = 0;
        int          checked = 0;

        function int due_count();
            return due_words.size();
        endfunction

        function void take_in_word(t_in_word w);
            t_out_word want;
            logic      start_seen;
            start_seen = inverse ? w.rx_level : ~w.rx_level;
            want = '0;
            case (w.cmd)
                CMD_LINE: begin
                    if (phase == LP_IDLE && start_seen) phase = LP_START;
                end
                CMD_TICK: begin
                    case (phase)
                        LP_START: begin
                            if (start_seen) begin
                                bit_mask = 8'd1;
                                shifter  = '0;
                                phase    = LP_HALF;
                            end else begin
                                phase = LP_IDLE;
                            end
                        end
                        LP_HALF: phase = (bit_mask == '0) ? LP_STOP : LP_DATA;
                        LP_DATA: begin
                            if (w.rx_level) shifter = shifter | bit_mask;
                            else shifter = shifter & ~bit_mask;
                            bit_mask = bit_mask << 1;
                            phase    = LP_HALF;
                        end
                        LP_STOP: begin
                            if (w.rx_level != inverse) begin
                                if ((wr_ptr + 1) % RING_DEPTH_DEF != rd_ptr) begin
                                    ring[wr_ptr] = inverse ? ~shifter : shifter;
                                    wr_ptr = (wr_ptr + 1) % RING_DEPTH_DEF;
                                end else begin
                                    want.byte_dropped = 1'b1;
                                end
                            end
                            phase = LP_IDLE;
                        end
                        default: ;
                    endcase
                end
                CMD_READ: begin
                    if (rd_ptr != wr_ptr) begin
                        want.rx_byte    = ring[rd_ptr];
                        want.byte_valid = 1'b1;
                        rd_ptr = (rd_ptr + 1) % RING_DEPTH_DEF;
                    end
                end
                default: begin
                    rd_ptr = 0;
                    wr_ptr = 0;
                end
            endcase
            want.frame_active = (phase != LP_IDLE);
            want.fill_count   = 6'((wr_ptr + RING_DEPTH_DEF - rd_ptr) % RING_DEPTH_DEF);
            due_words.push_back(want);
        endfunction

        task report(string msg);
            $display("ERROR word %0d: %s", checked, msg);
            errors++;
        endtask

        task check_field(string name, logic [7:0] got_v, logic [7:0] want_v);
            if (got_v !== want_v)
                report($sformatf("%s got %h want %h", name, got_v, want_v));
        endtask

        task check_out_word(t_out_word got);
            t_out_word want;
            if (due_words.size() == 0) begin
                report($sformatf("unexpected word %h", got));
            end else begin
                want = due_words.pop_front();
                check_field("rx_byte", got.rx_byte, want.rx_byte);
                check_field("byte_valid", got.byte_valid, want.byte_valid);
                check_field("frame_active", got.frame_active, want.frame_active);
                check_field("fill_count", got.fill_count, want.fill_count);
                check_field("byte_dropped", got.byte_dropped, want.byte_dropped);
                checked++;
            end
        endtask
    endclass

    logic      clk;
    logic      rst_n;
    logic      cfg_we;
    logic      cfg_wdata;
    logic      in_valid;
    logic      in_ready;
    t_in_word  in_word;
    logic      out_valid;
    logic      out_ready;
    t_out_word out_word;

    rx_ring_tracker board = new();
    int in_idle_pct  = 24;
    int out_idle_pct = 24;
    bit hold_req     = 1'b0;
    int stall_cycles = 0;

    uart_rx_halfbit_fifo DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_word  (out_word)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles + 1 >= STALL_LIMIT) begin
            $display("tb_uart_rx_halfbit_fifo NOT OK");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // result side: check accepted words, random backpressure, one long hold-off
    initial begin
        int hold_left;
        hold_left = 0;
        out_ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready) board.check_out_word(out_word);
            if (hold_req && hold_left == 0) begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end else begin
                out_ready <= (out_idle_pct == 0) || ($urandom_range(99) >= out_idle_pct);
            end
        end
    end

    task automatic send_word(input logic [1:0] cmd, input logic level);
        while (in_idle_pct != 0 && $urandom_range(99) < in_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= t_in_word'({cmd, level});
        do @(posedge clk); while (!in_ready);
        board.take_in_word(t_in_word'({cmd, level}));
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (board.due_count() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_inverse(input bit value);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        board.inverse = value;
        cfg_we <= 1'b0;
    endtask

    // tick inside a frame, sometimes preceded by a stray line event, read or flush
    task automatic frame_tick(input logic level, input int noise_pct);
        logic [1:0] stray;
        if ($urandom_range(99) < noise_pct) begin
            case ($urandom_range(2))
                0: stray = CMD_LINE;
                1: stray = CMD_READ;
                default: stray = CMD_FLUSH;
            endcase
            send_word(stray, 1'($urandom_range(1)));
        end
        send_word(CMD_TICK, level);
    endtask

    task automatic send_frame(input logic [7:0] data, input t_frame_fault fault,
                              input int noise_pct);
        logic inv;
        inv = board.inverse;
        send_word(CMD_LINE, inv);
        frame_tick((fault == FR_BAD_START) ? ~inv : inv, noise_pct);
        if (fault != FR_BAD_START) begin
            for (int i = 0; i < 8; i++) begin
                frame_tick(1'($urandom_range(1)), noise_pct);
                frame_tick(data[i] ^ inv, noise_pct);
            end
            frame_tick(1'($urandom_range(1)), noise_pct);
            frame_tick((fault == FR_BAD_STOP) ? inv : ~inv, noise_pct);
        end
    endtask

    task automatic run_frames(input int frames, input int read_pct, input int noise_pct,
                              input int fault_pct);
        logic [7:0]   data;
        t_frame_fault fault;
        int           roll;
        repeat (frames) begin
            while ($urandom_range(99) < read_pct) send_word(CMD_READ, 1'($urandom_range(1)));
            if ($urandom_range(99) < noise_pct)
                send_word(2'($urandom), 1'($urandom_range(1)));
            if ($urandom_range(9) == 0) data = $urandom_range(1) ? 8'hFF : 8'h00;
            else data = 8'($urandom);
            roll = $urandom_range(99);
            if (roll < fault_pct / 2) fault = FR_BAD_START;
            else if (roll < fault_pct) fault = FR_BAD_STOP;
            else fault = FR_GOOD;
            send_frame(data, fault, noise_pct);
        end
    endtask

    initial begin
        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_wdata <= 1'b0;
        in_valid  <= 1'b0;
        in_word   <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        set_inverse(1'b0);

        send_word(CMD_TICK, 1'b1);      // tick while idle
        send_word(CMD_LINE, 1'b1);      // no start level
        send_word(CMD_READ, 1'b0);      // empty ring
        send_word(CMD_LINE, 1'b0);
        send_word(CMD_LINE, 1'b0);      // already in a frame
        set_inverse(1'b1);              // polarity flip mid-frame
        send_word(CMD_TICK, 1'b0);      // start re-check fails
        set_inverse(1'b0);
        send_frame(8'hA5, FR_GOOD, 0);
        send_word(CMD_READ, 1'b1);
        send_word(CMD_FLUSH, 1'b0);

        run_frames(3, 40, 10, 20);

        // fill the ring to overflow; the result side holds off as the frames begin
        set_inverse(1'b1);
        hold_req = 1'b1;
        run_frames(66, 0, 0, 0);
        repeat (64) send_word(CMD_READ, 1'($urandom_range(1)));

        in_idle_pct  = 0;
        out_idle_pct = 0;
        run_frames(5, 40, 10, 20);

        set_inverse(1'b0);
        in_idle_pct  = 24;
        out_idle_pct = 24;
        run_frames(4, 40, 15, 20);

        wait_idle();
        if (board.errors == 0 && board.due_count() == 0) begin
            $display("tb_uart_rx_halfbit_fifo OK");
        end else begin
            $display("tb_uart_rx_halfbit_fifo NOT OK");
        end
        $finish;
    end

endmodule
